>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by kmeans_grid_clustering
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hw/rtl/kmg_pkg.sv
// ----------------------------------------------------------------------------
// kmg_pkg
// shared types and codes for the grid clustering block
// ----------------------------------------------------------------------------
`default_nettype none
package kmg_pkg;
   localparam int SIDE_RESET  = 5;
   localparam int LIMIT_RESET = 100;
   localparam logic CSR_GRID_SIDE = 1'b0;
   localparam logic CSR_ITER_LIMIT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic seed_wr;     // store a seed
      logic round_init;  // latch labels, clear sums
      logic scan_clr;    // reset point scan
      logic scan_step;   // assign one point
      logic div_start;   // start divide of cluster div_sel
      logic div_commit;  // write quotients
      logic out_load;    // load result of cluster div_sel
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic same;
   } stat_type;
endpackage
`default_nettype wire

>>> hw/rtl/kmg_datapath.sv
// ----------------------------------------------------------------------------
// kmg_datapath
// centroid store, point scanner, accumulators and serial divider
// ----------------------------------------------------------------------------
`default_nettype none
module kmg_datapath #(
   parameter int CLUSTERS = 3,
   parameter int GRID_MAX = 16,
   parameter int KW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1,
   parameter int CW = $clog2(GRID_MAX),
   parameter int LW = 2 * CW + 1,
   parameter int SW = 3 * CW,
   parameter int NW = 2 * CW + 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire kmg_pkg::cmd_type cmd,
   output kmg_pkg::stat_type    stat,
   input  wire logic [KW-1:0]   div_sel,
   input  wire logic [CW:0]     side,
   input  wire logic [8:0]      seed_label,
   output logic [CW-1:0]        out_row,
   output logic [CW-1:0]        out_col,
   output logic [LW-1:0]        out_label,
   output logic [NW-1:0]        out_count
);
   import kmg_pkg::*;

   logic [CW-1:0] row_ff [CLUSTERS];
   logic [CW-1:0] col_ff [CLUSTERS];
   logic [LW-1:0] prev_ff [CLUSTERS];
   logic [SW-1:0] rsum_ff [CLUSTERS];
   logic [SW-1:0] csum_ff [CLUSTERS];
   logic [NW-1:0] cnt_ff [CLUSTERS];
   logic [CW-1:0] pr_ff, pc_ff;
   logic          scan_done_ff;
   logic [SW-1:0] rem_r_ff, rem_c_ff, q_r_ff, q_c_ff;
   logic [NW-1:0] divisor_ff;
   logic [5:0]    dbit_ff;
   logic          dbusy_ff, ddone_ff;

   function automatic logic [LW-1:0] label_of(logic [CW-1:0] r, logic [CW-1:0] c,
                                              logic [CW:0] s);
      logic [2*CW+1:0] p;
      p = r * s;
      return LW'(p + c + 1);
   endfunction

   // seed conversion: label minus one split by side through a short search
   logic [8:0]    lm1;
   logic          seed_ok;
   logic [CW-1:0] seed_r, seed_c;
   logic [KW-1:0] seed_slot_ff;
   always_comb begin
      lm1 = seed_label - 9'd1;
      seed_ok = (seed_label != 9'd0) && ({1'b0, seed_label} <= 10'(side * side));
      seed_r = '0;
      seed_c = '0;
      for (int i = 0; i < GRID_MAX; i++) begin
         if (10'(lm1) >= 10'(i * side) && 10'(lm1) < 10'((i + 1) * side)) begin
            seed_r = CW'(i);
            seed_c = CW'(10'(lm1) - 10'(i * side));
         end
      end
   end

   // nearest centroid for current point
   logic [KW-1:0] best;
   always_comb begin
      logic [2*CW+1:0] bd, d;
      logic [CW-1:0] dr, dc;
      best = '0;
      bd = '1;
      for (int k = 0; k < CLUSTERS; k++) begin
         dr = (pr_ff > row_ff[k]) ? pr_ff - row_ff[k] : row_ff[k] - pr_ff;
         dc = (pc_ff > col_ff[k]) ? pc_ff - col_ff[k] : col_ff[k] - pc_ff;
         d = (2*CW+2)'(dr * dr) + (2*CW+2)'(dc * dc);
         if (k == 0 || d < bd) begin
            bd = d;
            best = KW'(k);
         end
      end
   end

   // centroid store and seed slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLUSTERS; k++) begin
            row_ff[k] <= '0;
            col_ff[k] <= '0;
         end
         seed_slot_ff <= '0;
      end else begin
         if (cmd.seed_wr) begin
            if (seed_ok) begin
               row_ff[seed_slot_ff] <= seed_r;
               col_ff[seed_slot_ff] <= seed_c;
            end
            seed_slot_ff <= (32'(seed_slot_ff) + 1 >= CLUSTERS) ? '0 : seed_slot_ff + 1'b1;
         end
         if (cmd.round_init) seed_slot_ff <= '0;
         if (cmd.div_commit && cnt_ff[div_sel] != '0) begin
            row_ff[div_sel] <= CW'(q_r_ff);
            col_ff[div_sel] <= CW'(q_c_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_init) begin
         for (int k = 0; k < CLUSTERS; k++) begin
            prev_ff[k] <= label_of(row_ff[k], col_ff[k], side);
            rsum_ff[k] <= '0;
            csum_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
      end else if (cmd.scan_step && !scan_done_ff) begin
         rsum_ff[best] <= rsum_ff[best] + SW'(pr_ff);
         csum_ff[best] <= csum_ff[best] + SW'(pc_ff);
         cnt_ff[best]  <= cnt_ff[best] + 1'b1;
      end
   end

   // point scanner
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clr) begin
         pr_ff <= '0;
         pc_ff <= '0;
         scan_done_ff <= 1'b0;
      end else if (cmd.scan_step && !scan_done_ff) begin
         if ({1'b0, pc_ff} == side - 1'b1) begin
            pc_ff <= '0;
            if ({1'b0, pr_ff} == side - 1'b1) scan_done_ff <= 1'b1;
            else pr_ff <= pr_ff + 1'b1;
         end else begin
            pc_ff <= pc_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit a cycle for both sums
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else if (cmd.div_start) begin
         rem_r_ff <= '0;
         rem_c_ff <= '0;
         q_r_ff <= rsum_ff[div_sel];
         q_c_ff <= csum_ff[div_sel];
         divisor_ff <= cnt_ff[div_sel];
         dbit_ff <= 6'(SW);
         dbusy_ff <= 1'b1;
         ddone_ff <= 1'b0;
      end else if (dbusy_ff) begin
         logic [SW:0] tr, tc;
         tr = {rem_r_ff, q_r_ff[SW-1]};
         tc = {rem_c_ff, q_c_ff[SW-1]};
         if (tr >= (SW+1)'(divisor_ff)) begin
            rem_r_ff <= SW'(tr - (SW+1)'(divisor_ff));
            q_r_ff <= {q_r_ff[SW-2:0], 1'b1};
         end else begin
            rem_r_ff <= SW'(tr);
            q_r_ff <= {q_r_ff[SW-2:0], 1'b0};
         end
         if (tc >= (SW+1)'(divisor_ff)) begin
            rem_c_ff <= SW'(tc - (SW+1)'(divisor_ff));
            q_c_ff <= {q_c_ff[SW-2:0], 1'b1};
         end else begin
            rem_c_ff <= SW'(tc);
            q_c_ff <= {q_c_ff[SW-2:0], 1'b0};
         end
         dbit_ff <= dbit_ff - 1'b1;
         if (dbit_ff == 6'd1) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end else begin
         ddone_ff <= 1'b0;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_row <= row_ff[div_sel];
         out_col <= col_ff[div_sel];
         out_label <= label_of(row_ff[div_sel], col_ff[div_sel], side);
         out_count <= cnt_ff[div_sel];
      end
   end

   assign stat.scan_done = scan_done_ff;
   assign stat.div_done  = ddone_ff;
   assign stat.same = label_of(row_ff[div_sel], col_ff[div_sel], side) == prev_ff[div_sel];
endmodule
`default_nettype wire

>>> hw/rtl/kmg_control.sv
// ----------------------------------------------------------------------------
// kmg_control
// sequencer for seeding, rounds, mean update and result transfer
// ----------------------------------------------------------------------------
`default_nettype none
module kmg_control #(
   parameter int CLUSTERS = 3,
   parameter int KW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             seed_last,
   input  wire logic [7:0]       limit,
   output logic                  busy,
   output kmg_pkg::cmd_type      cmd,
   input  wire kmg_pkg::stat_type stat,
   output logic [KW-1:0]         sel,
   output logic                  out_valid,
   output logic                  out_conv,
   output logic [7:0]            out_rounds,
   output logic                  out_last
);
   import kmg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_INIT = 3'd1, ST_SCAN = 3'd2,
                          ST_DIV = 3'd3, ST_WAIT = 3'd4, ST_CHECK = 3'd5,
                          ST_OUT = 3'd6, ST_SHOW = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [KW-1:0] sel_ff, sel_in;
   logic [7:0]    round_ff, round_in;
   logic          same_ff, same_in, conv_ff, conv_in, valid_ff, valid_in;

   wire last_k = (32'(sel_ff) == CLUSTERS - 1);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      round_in = round_ff;
      same_in = same_ff;
      conv_in = conv_ff;
      valid_in = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.seed_wr = 1'b1;
               if (seed_last) begin
                  round_in = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.round_init = 1'b1;
            cmd.scan_clr = 1'b1;
            same_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               sel_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.div_done) begin
               cmd.div_commit = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.same) same_in = 1'b0;
            if (last_k) begin
               round_in = round_ff + 1'b1;
               sel_in = '0;
               if (same_ff && stat.same) begin
                  conv_in = 1'b1;
                  state_in = ST_OUT;
               end else if (round_ff + 1'b1 >= ((limit == 8'd0) ? 8'd1 : limit)) begin
                  conv_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_INIT;
               end
            end else begin
               sel_in = sel_ff + 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            cmd.out_load = 1'b1;
            valid_in = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (last_k) begin
               sel_in = '0;
               state_in = ST_IDLE;
            end else begin
               sel_in = sel_ff + 1'b1;
               state_in = ST_OUT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= '0;
         round_ff <= '0;
         same_ff <= 1'b0;
         conv_ff <= 1'b0;
         valid_ff <= 1'b0;
         out_last <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         round_ff <= round_in;
         same_ff <= same_in;
         conv_ff <= conv_in;
         valid_ff <= valid_in;
         if (valid_in) out_last <= last_k;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign sel = sel_ff;
   assign out_valid = valid_ff;
   assign out_conv = conv_ff;
   assign out_rounds = round_ff;
endmodule
`default_nettype wire

>>> hw/rtl/kmeans_grid_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_grid_clustering
// k-means over every point of a square grid, seeded by grid labels
// ----------------------------------------------------------------------------
// Seeds are taken one per cycle while busy is low. The seed marked last
// starts the run: each round scans side*side points at one per cycle, then
// divides each cluster's sums in a bit-serial divider, one cluster after
// another, and a run takes up to iteration_limit rounds. The results follow
// one by one, never back to back, each on the rsp_ ports for one cycle with
// rsp_valid; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module kmeans_grid_clustering #(
   parameter int CLUSTERS = 3,
   parameter int GRID_MAX = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [8:0]  req_seed_label,
   input  wire logic        req_seed_last,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data,
   output logic             rsp_valid,
   output logic [1:0]       rsp_cluster_index,
   output logic [3:0]       rsp_centroid_row,
   output logic [3:0]       rsp_centroid_col,
   output logic [8:0]       rsp_centroid_label,
   output logic [8:0]       rsp_member_count,
   output logic             rsp_converged,
   output logic [7:0]       rsp_rounds_used,
   output logic             rsp_last_cluster
);
   import kmg_pkg::*;

   localparam int KW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int CW = $clog2(GRID_MAX);
   localparam int LW = 2 * CW + 1;
   localparam int NW = 2 * CW + 1;

   logic [4:0] side_reg_ff;
   logic [7:0] limit_ff;
   logic [CW:0] side;
   cmd_type cmd;
   stat_type stat;
   logic [KW-1:0] sel, idx_ff;
   logic [CW-1:0] o_row, o_col;
   logic [LW-1:0] o_label;
   logic [NW-1:0] o_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_reg_ff <= 5'(SIDE_RESET);
         limit_ff <= 8'(LIMIT_RESET);
      end else if (csr_write) begin
         if (csr_index == CSR_GRID_SIDE) side_reg_ff <= csr_data[4:0];
         else limit_ff <= csr_data;
      end
   end

   // clamp side to 1..GRID_MAX
   always_comb begin
      if (side_reg_ff == 5'd0) side = (CW+1)'(1);
      else if (32'(side_reg_ff) > GRID_MAX) side = (CW+1)'(GRID_MAX);
      else side = (CW+1)'(side_reg_ff);
   end

   kmg_control #(.CLUSTERS(CLUSTERS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .seed_last(req_seed_last),
      .limit(limit_ff), .busy(busy), .cmd(cmd), .stat(stat), .sel(sel),
      .out_valid(rsp_valid), .out_conv(rsp_converged),
      .out_rounds(rsp_rounds_used), .out_last(rsp_last_cluster)
   );

   kmg_datapath #(.CLUSTERS(CLUSTERS), .GRID_MAX(GRID_MAX)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .div_sel(sel),
      .side(side), .seed_label(req_seed_label), .out_row(o_row), .out_col(o_col),
      .out_label(o_label), .out_count(o_count)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_load) idx_ff <= sel;
   end

   assign rsp_cluster_index  = 2'(idx_ff);
   assign rsp_centroid_row   = 4'(o_row);
   assign rsp_centroid_col   = 4'(o_col);
   assign rsp_centroid_label = 9'(o_label);
   assign rsp_member_count   = 9'(o_count);

   `ASSERT_IMPLY(a_no_rsp_idle, clock, reset, !busy, !rsp_valid)
   `ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLY(a_rounds_nonzero, clock, reset, rsp_valid, rsp_rounds_used != 8'd0)
endmodule
`default_nettype wire
